// ===== design/apm_pkg.sv =====
// shared types, constants and helpers for the power-to-energy accumulator
// used by apm_div_const and apm_power_energy_accumulator; no dependencies
package apm_pkg;

  // number of packages with an energy store
  localparam int PACKAGES = 8;
  localparam int PKG_AW   = (PACKAGES > 1) ? $clog2(PACKAGES) : 1;

  // power conversion constants
  localparam int WATT_SCALE = 15625;
  localparam int SHIFT_BASE = 10;

  // energy divide by one million: drop six bits, then divide by 15625
  localparam int DIV_K     = 15625;
  localparam int DIV_PRE   = 6;
  localparam int DIV_DIG_W = 4;
  localparam int DIV_STEPS = 15;
  localparam int DIV_DVD_W = DIV_STEPS * DIV_DIG_W;
  localparam int DIV_REM_W = 14;
  localparam int DIV_V_W   = DIV_REM_W + DIV_DIG_W;
  localparam int DIV_QUO_W = 48;
  localparam int DIV_CNT_W = 4;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_REGISTER_MODE = 2'd0,
    CFG_BASE_TDP      = 2'd1,
    CFG_TDP_TO_WATTS  = 2'd2
  } cfg_idx_t;

  // divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // multiple of the divisor for one radix-16 digit
  function automatic logic [DIV_V_W-1:0] div_mult(input logic [DIV_DIG_W-1:0] d);
    return DIV_V_W'(d) * DIV_V_W'(DIV_K);
  endfunction

endpackage

// ===== design/apm_power_energy_accumulator.sv =====
// power-to-energy accumulator top level: sequencer, shared multiplier, energy store
// depends on apm_pkg and apm_div_const
//
// Each request carries one power sample for one package. In register mode the power
// in microwatts is computed from the running-average and TDP-limit words with the
// programmed base TDP and conversion factor; in direct mode the given microwatt value
// is used. The energy power*elapsed_us/1000000 is added to that package's 64-bit store
// (cleared at reset, wraps) and one result with the power and the new energy is sent.
// Requests are handled one at a time; a new request is taken only once the last result
// has entered the result register, which waits while the output is full. In register
// mode a request makes four passes through one shared 32x32 multiplier (direct mode
// uses only the power*elapsed pass), then the radix-16 divide by one million runs.
// A new request is taken while the previous result still waits on the output.
// Configuration must be written only while no request is in flight (not enforced here).
module apm_power_energy_accumulator
  import apm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_package_req,
  input  logic [31:0] in_average_word,
  input  logic [31:0] in_limit_word,
  input  logic [31:0] in_direct_power_uw,
  input  logic [31:0] in_elapsed_us,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_power_uw,
  output logic [63:0] out_energy_uj,
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MK,
    S_MLO,
    S_MHI,
    S_PWR,
    S_SHF,
    S_EMUL,
    S_DSTART,
    S_DWAIT,
    S_WB
  } state_t;

  state_t st_r;

  // configuration registers
  logic        mode_r;
  logic [15:0] base_r;
  logic [15:0] tdp_r;

  // request registers
  logic [PKG_AW-1:0] pkg_r;
  logic              pkg_ok_r;
  logic [31:0]       avg_r;
  logic [15:0]       lim_r;
  logic [31:0]       dir_r;
  logic [31:0]       elap_r;

  // datapath registers
  logic [63:0] p_r;
  logic [29:0] k_r;
  logic [63:0] acc_r;
  logic [63:0] mul_r;
  logic [31:0] power_r;

  // result registers
  logic        out_valid_r;
  logic [31:0] out_power_r;
  logic [63:0] out_energy_r;

  // energy store
  logic [63:0]         mem [PACKAGES];
  logic [PACKAGES-1:0] vld_r;
  logic [63:0]         rd_r;
  logic                mem_we;
  logic [63:0]         mem_wd;

  logic        in_acc;
  logic        out_free;
  logic [4:0]  range_w;
  logic [5:0]  sh_w;
  logic [16:0] sum_w;
  logic [63:0] cap_w;
  logic [63:0] p_nxt;
  logic [63:0] shifted_w;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_res;
  logic [63:0] old_energy;
  logic [63:0] new_energy;
  logic        div_start;
  logic [DIV_QUO_W-1:0] div_q;
  div_stat_t   div_stat;

  assign in_ready  = (st_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_power_uw  = out_power_r;
  assign out_energy_uj = out_energy_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      base_r <= '0;
      tdp_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_REGISTER_MODE: mode_r <= cfg_wdata[0];
        CFG_BASE_TDP:      base_r <= cfg_wdata;
        CFG_TDP_TO_WATTS:  tdp_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // raw power before scaling: ((limit + base) << range) - capture
  always_comb begin
    range_w = {1'b0, avg_r[3:0]} + 5'd1;
    sh_w    = {1'b0, range_w} + 6'(SHIFT_BASE);
    sum_w   = {1'b0, lim_r} + {1'b0, base_r};
    cap_w   = {{42{avg_r[25]}}, avg_r[25:4]};
    p_nxt   = (64'(sum_w) << range_w) - cap_w;
  end

  assign shifted_w = acc_r >> sh_w;

  // shared multiplier operand select
  always_comb begin
    unique case (st_r)
      S_MK: begin
        mul_a = 32'(tdp_r);
        mul_b = 32'(WATT_SCALE);
      end
      S_MLO: begin
        mul_a = p_r[31:0];
        mul_b = mul_r[31:0];
      end
      S_MHI: begin
        mul_a = p_r[63:32];
        mul_b = 32'(k_r);
      end
      default: begin
        mul_a = power_r;
        mul_b = elap_r;
      end
    endcase
  end

  assign mul_res = 64'(mul_a) * 64'(mul_b);

  // energy update
  assign old_energy = vld_r[pkg_r] ? rd_r : 64'd0;
  assign new_energy = old_energy + 64'(div_q);
  assign mem_we     = (st_r == S_WB) && out_free && pkg_ok_r;
  assign mem_wd     = new_energy;
  assign div_start  = (st_r == S_DSTART);

  // energy store: read at acceptance, write back at the end
  always_ff @(posedge clk) begin
    if (in_acc) rd_r <= mem[PKG_AW'(in_package_req)];
    if (mem_we) mem[pkg_r] <= mem_wd;
  end

  // entry valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (mem_we) begin
      vld_r[pkg_r] <= 1'b1;
    end
  end

  // divide by one million
  apm_div_const u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mul_r),
    .quotient (div_q),
    .stat     (div_stat)
  );

  // sequencer and result register
  always_ff @(posedge clk) begin
    mul_r <= mul_res;
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && (st_r != S_WB)) out_valid_r <= 1'b0;
      unique case (st_r)
        S_IDLE: begin
          if (in_acc) begin
            pkg_r    <= PKG_AW'(in_package_req);
            pkg_ok_r <= (32'(in_package_req) < 32'(PACKAGES));
            avg_r    <= in_average_word;
            lim_r    <= in_limit_word[31:16];
            dir_r    <= in_direct_power_uw;
            elap_r   <= in_elapsed_us;
            st_r     <= S_MK;
          end
        end
        S_MK: begin
          p_r <= p_nxt;
          if (mode_r) begin
            st_r <= S_MLO;
          end else begin
            power_r <= dir_r;
            st_r    <= S_EMUL;
          end
        end
        S_MLO: begin
          k_r  <= mul_r[29:0];
          st_r <= S_MHI;
        end
        S_MHI: begin
          acc_r <= mul_r;
          st_r  <= S_PWR;
        end
        S_PWR: begin
          acc_r <= acc_r + {mul_r[31:0], 32'd0};
          st_r  <= S_SHF;
        end
        S_SHF: begin
          power_r <= shifted_w[31:0];
          st_r    <= S_EMUL;
        end
        S_EMUL: begin
          st_r <= S_DSTART;
        end
        S_DSTART: begin
          st_r <= S_DWAIT;
        end
        S_DWAIT: begin
          if (div_stat.done) st_r <= S_WB;
        end
        S_WB: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_power_r  <= power_r;
            out_energy_r <= pkg_ok_r ? new_energy : 64'd0;
            st_r         <= S_IDLE;
          end else begin
            out_valid_r  <= 1'b1;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  // checks
  a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (st_r == S_MK)) else $error("request accepted without starting");
  a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (st_r == S_WB && out_free)) else $error("store written outside write-back");
  a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (st_r == S_DWAIT)) else $error("divider finished unexpectedly");
  a_start_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy) else $error("divider restarted while busy");

endmodule

// ===== design/apm_div_const.sv =====
// radix-16 long divider by the constant 15625 after dropping six dividend bits, one quotient digit per cycle
// depends on apm_pkg
module apm_div_const
  import apm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [63:0]          dividend,
  output logic [DIV_QUO_W-1:0] quotient,
  output div_stat_t            stat
);

  logic [DIV_DVD_W-1:0] dvd_r;
  logic [DIV_REM_W-1:0] rem_r;
  logic [DIV_QUO_W-1:0] quo_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [DIV_V_W-1:0]   v;
  logic [DIV_DIG_W-1:0] digit;
  logic [DIV_V_W-1:0]   rem_full;

  // partial remainder joined with the next dividend digit
  assign v = {rem_r, dvd_r[DIV_DVD_W-1 -: DIV_DIG_W]};

  // pick the largest digit whose multiple fits
  always_comb begin
    digit = '0;
    for (int d = 1; d < (1 << DIV_DIG_W); d++) begin
      if (v >= div_mult(DIV_DIG_W'(d))) digit = DIV_DIG_W'(d);
    end
    rem_full = v - div_mult(digit);
  end

  // step sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !start && (cnt_r == DIV_CNT_W'(DIV_STEPS - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        dvd_r  <= DIV_DVD_W'(dividend >> DIV_PRE);
        rem_r  <= '0;
        quo_r  <= '0;
      end else if (busy_r) begin
        dvd_r <= dvd_r << DIV_DIG_W;
        rem_r <= rem_full[DIV_REM_W-1:0];
        quo_r <= {quo_r[DIV_QUO_W-DIV_DIG_W-1:0], digit};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

  // checks
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("divider started while busy");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r) else $error("divider did not start");
  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !start && cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) |=> (done_r && !busy_r))
    else $error("divider missed its last step");

endmodule
